// ===== sv/blmr_pkg.sv =====
// Package for the bivariate local Moran row engine.
// Shared types and constants; no dependencies.
package blmr_pkg;

	localparam int ACC_W  = 56;
	localparam int WSUM_W = 24;
	localparam int QUO_W  = 33;

	localparam logic [2:0] CL_UNDEF    = 3'd0;
	localparam logic [2:0] CL_ISOLATED = 3'd1;
	localparam logic [2:0] CL_HH       = 3'd2;
	localparam logic [2:0] CL_LL       = 3'd3;
	localparam logic [2:0] CL_LH       = 3'd4;
	localparam logic [2:0] CL_HL       = 3'd5;
	localparam logic [2:0] CL_NS       = 3'd6;

	// finished row handed from front to back
	typedef struct packed {
		logic [19:0]              idx;
		logic signed [31:0]       z1;
		logic                     direct;
		logic [2:0]               dcl;
		logic signed [ACC_W-1:0]  wsum;
		logic [WSUM_W-1:0]        ws;
	} row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} back_state_t;

endpackage

// ===== sv/blmr_front.sv =====
// Front part: accumulates one row of sparse entries and emits a row record.
// Depends on blmr_pkg.
module blmr_front #(
	parameter int MAX_OBS = 1048576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [19:0]         focal_index,
	input  logic signed [31:0]  focal_z1,
	input  logic                focal_undefined,
	input  logic                row_empty,
	input  logic [19:0]         neighbor_index,
	input  logic [16:0]         neighbor_weight,
	input  logic signed [31:0]  neighbor_z2,
	input  logic                neighbor_undefined,
	input  logic                last_in_row,
	output logic                row_valid,
	output blmr_pkg::row_t      row
);
	localparam int AW = blmr_pkg::ACC_W;
	localparam int WW = blmr_pkg::WSUM_W;

	logic signed [AW-1:0] wsum_q;
	logic [WW-1:0]        ws_q;
	logic                 keep;
	logic signed [49:0]   prod;
	logic signed [AW:0]   acc_sum;
	logic signed [AW-1:0] acc_new;
	logic [WW:0]          ws_sum;
	logic [WW-1:0]        ws_new;
	logic                 in_range;

	always_comb begin
		in_range = ({5'd0, neighbor_index} < 25'(MAX_OBS));
		keep = (neighbor_index != focal_index) && !neighbor_undefined && in_range;
		prod = $signed({1'b0, neighbor_weight}) * neighbor_z2;
		acc_sum = {wsum_q[AW-1], wsum_q} + (AW+1)'(prod);
		if (acc_sum[AW] != acc_sum[AW-1])
			acc_new = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		else
			acc_new = acc_sum[AW-1:0];
		ws_sum = {1'b0, ws_q} + (WW+1)'(neighbor_weight);
		ws_new = ws_sum[WW] ? {WW{1'b1}} : ws_sum[WW-1:0];
		if (!keep) begin
			acc_new = wsum_q;
			ws_new = ws_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			ws_q <= '0;
		end else if (in_valid) begin
			if (focal_undefined || row_empty || last_in_row) begin
				wsum_q <= '0;
				ws_q <= '0;
			end else begin
				wsum_q <= acc_new;
				ws_q <= ws_new;
			end
		end
	end

	always_comb begin
		row_valid = in_valid && (focal_undefined || row_empty || last_in_row);
		row.idx = focal_index;
		row.z1 = focal_z1;
		row.direct = focal_undefined || row_empty;
		row.dcl = focal_undefined ? blmr_pkg::CL_UNDEF : blmr_pkg::CL_ISOLATED;
		row.wsum = acc_new;
		row.ws = ws_new;
	end
endmodule

// ===== sv/blmr_fifo.sv =====
// Small queue of row records between front and back.
// Depends on blmr_pkg.
module blmr_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  blmr_pkg::row_t  wdata,
	output logic            full,
	input  logic            rd,
	output logic            empty,
	output blmr_pkg::row_t  rdata
);
	localparam int PW = $clog2(DEPTH);

	blmr_pkg::row_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end
endmodule

// ===== sv/blmr_back.sv =====
// Back part: restoring divide for the lag, z1*lag multiply, classification.
// Depends on blmr_pkg.
module blmr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  blmr_pkg::row_t      q_data,
	output logic                q_rd,
	output logic                empty,
	input  logic                pop,
	output logic [19:0]         row_index,
	output logic signed [31:0]  bimoran,
	output logic signed [31:0]  spatial_lag,
	output logic [2:0]          cluster
);
	localparam int AW = blmr_pkg::ACC_W;
	localparam int WW = blmr_pkg::WSUM_W;
	localparam int QW = blmr_pkg::QUO_W;

	blmr_pkg::back_state_t st_q, st_d;
	logic [19:0]         idx_q;
	logic signed [31:0]  z1_q;
	logic                neg_q;
	logic [AW-1:0]       num_q;
	logic [WW:0]         rem_q;
	logic [WW-1:0]       den_q;
	logic [5:0]          cnt_q;
	logic signed [31:0]  lag_q;
	logic signed [63:0]  prod_q;
	logic signed [31:0]  bim_q;
	logic [2:0]          cl_q;
	logic                out_ok_q;

	logic [WW:0]         rem_sh;
	logic [WW+1:0]       trial;
	logic [AW-1:0]       mag;
	logic [QW-1:0]       qmag;
	logic [63:0]         pmag;
	logic [39:0]         bmag;

	always_comb begin
		rem_sh = {rem_q[WW-1:0], num_q[AW-1]};
		trial = {1'b0, rem_sh} - {2'b0, den_q};
		mag = q_data.wsum[AW-1] ? AW'(-q_data.wsum) : q_data.wsum;
		// quotient can reach 2^55; clamp to 2^31 magnitude
		qmag = (num_q > AW'(33'h80000000)) ? QW'(33'h80000000) : QW'(num_q);
		pmag = prod_q[63] ? 64'(-prod_q) : prod_q;
		bmag = pmag[63:24];
	end

	always_comb begin
		st_d = st_q;
		q_rd = 1'b0;
		case (st_q)
			blmr_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_rd = 1'b1;
					if (q_data.direct) st_d = blmr_pkg::ST_OUT;
					else if (q_data.ws == '0) st_d = blmr_pkg::ST_MUL;
					else st_d = blmr_pkg::ST_DIV;
				end
			end
			blmr_pkg::ST_DIV: if (cnt_q == 6'(AW-1)) st_d = blmr_pkg::ST_MUL;
			blmr_pkg::ST_MUL: st_d = blmr_pkg::ST_FIN;
			blmr_pkg::ST_FIN: st_d = blmr_pkg::ST_OUT;
			blmr_pkg::ST_OUT: if (pop && out_ok_q) st_d = blmr_pkg::ST_IDLE;
			default: st_d = blmr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= blmr_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			blmr_pkg::ST_IDLE: begin
				idx_q <= q_data.idx;
				z1_q <= q_data.z1;
				neg_q <= q_data.wsum[AW-1];
				num_q <= (q_data.ws == '0) ? '0 : mag;
				den_q <= q_data.ws;
				rem_q <= '0;
				cnt_q <= '0;
				lag_q <= '0;
				prod_q <= '0;
				bim_q <= '0;
				cl_q <= q_data.dcl;
			end
			blmr_pkg::ST_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (!trial[WW+1]) begin
					rem_q <= trial[WW:0];
					num_q <= {num_q[AW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					num_q <= {num_q[AW-2:0], 1'b0};
				end
			end
			blmr_pkg::ST_MUL: begin
				lag_q <= neg_q ? 32'(-qmag)
					: ((qmag > QW'(32'h7fffffff)) ? 32'h7fffffff : qmag[31:0]);
				prod_q <= '0;
			end
			blmr_pkg::ST_FIN: begin
				bim_q <= '0;
				if (z1_q > 0 && lag_q > 0) cl_q <= blmr_pkg::CL_HH;
				else if (z1_q < 0 && lag_q < 0) cl_q <= blmr_pkg::CL_LL;
				else if (z1_q < 0 && lag_q > 0) cl_q <= blmr_pkg::CL_LH;
				else if (z1_q > 0 && lag_q < 0) cl_q <= blmr_pkg::CL_HL;
				else cl_q <= blmr_pkg::CL_NS;
				prod_q <= z1_q * lag_q;
			end
			blmr_pkg::ST_OUT: begin
				if (!prod_q[63])
					bim_q <= (bmag > 40'h7fffffff) ? 32'h7fffffff : bmag[31:0];
				else
					bim_q <= (bmag >= 40'h80000000) ? 32'h80000000 : 32'(-bmag);
			end
			default: ;
		endcase
	end

	// bimoran is registered while in ST_OUT; hold empty until it has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ok_q <= 1'b0;
		else out_ok_q <= (st_q == blmr_pkg::ST_OUT) && !(out_ok_q && pop);
	end

	assign empty = !(st_q == blmr_pkg::ST_OUT && out_ok_q);
	assign row_index = idx_q;
	assign bimoran = bim_q;
	assign spatial_lag = lag_q;
	assign cluster = cl_q;
endmodule

// ===== sv/bivariate_local_moran_row.sv =====
// Bivariate local Moran row engine, top level.
// Depends on blmr_pkg, blmr_front, blmr_fifo, blmr_back.
//
// Input queue: push/full carries one sparse row entry per word. Entries
// are taken one per cycle while full is low; the front accumulates weight*z2
// and the weight sum for the row in the same cycle it accepts the word.
// Result queue: empty/pop; the oldest result sits on the ports while empty
// is low. One result per finished row (last entry, undefined focal or
// empty row); middle entries give none.
// Back part: a 56-step restoring divider forms the lag (one quotient bit
// per cycle), followed by multiply, classify and saturate steps. Rows
// with no kept weight skip the divider; direct rows go straight to output.
// Throughput: one entry per cycle while the row queue (DEPTH records) has
// room; finished rows drain one at a time, as the back part reads the next
// record only after the previous result has been popped.
// Reset clears the sums, the queue and the back state machine.
// A stalled receiver holds the result; full rises when the queue fills.
module bivariate_local_moran_row #(
	parameter int MAX_OBSERVATIONS = 1048576,
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [19:0]         focal_index,
	input  logic signed [31:0]  focal_z1,
	input  logic                focal_undefined,
	input  logic                row_empty,
	input  logic [19:0]         neighbor_index,
	input  logic [16:0]         neighbor_weight,
	input  logic signed [31:0]  neighbor_z2,
	input  logic                neighbor_undefined,
	input  logic                last_in_row,
	output logic                empty,
	input  logic                pop,
	output logic [19:0]         row_index,
	output logic signed [31:0]  bimoran,
	output logic signed [31:0]  spatial_lag,
	output logic [2:0]          cluster
);
	logic           acc;
	logic           row_valid;
	blmr_pkg::row_t row_w, q_data;
	logic           q_empty, q_rd;

	assign acc = push && !full;

	blmr_front #(.MAX_OBS(MAX_OBSERVATIONS)) u_front (
		.clk, .arst_n, .in_valid(acc),
		.focal_index, .focal_z1, .focal_undefined, .row_empty,
		.neighbor_index, .neighbor_weight, .neighbor_z2,
		.neighbor_undefined, .last_in_row,
		.row_valid, .row(row_w)
	);

	blmr_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk, .arst_n, .wr(row_valid), .wdata(row_w), .full,
		.rd(q_rd), .empty(q_empty), .rdata(q_data)
	);

	blmr_back u_back (
		.clk, .arst_n, .q_empty, .q_data, .q_rd,
		.empty, .pop, .row_index, .bimoran, .spatial_lag, .cluster
	);
endmodule

// ===== tb/tb_top.sv =====
// Testbench for bivariate_local_moran_row: drives sparse row entries and
// checks each finished-row word against a built-in fixed-point predictor.
// Depends on blmr_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
	localparam int MAX_OBS = 1048576;
	localparam int N_RANDOM = 900;

	typedef struct {
		logic [19:0]        idx;
		logic signed [31:0] bim;
		logic signed [31:0] lag;
		logic [2:0]         cl;
	} row_result_t;

	class moran_scoreboard;
		logic signed [55:0] acc_sum;
		logic [23:0]        wt_sum;
		row_result_t        pending[$];
		int                 errors;
		int                 rows_seen;

		function new();
			acc_sum = '0;
			wt_sum = '0;
			errors = 0;
			rows_seen = 0;
		endfunction

		// note one accepted entry word
		function void note_entry(logic [19:0] fi, logic signed [31:0] z1, logic fu,
			logic re, logic [19:0] ni, logic [16:0] w, logic signed [31:0] z2,
			logic nu, logic last);
			row_result_t r;
			longint p, acc, mag, lagv, prod;
			longint unsigned um;
			int unsigned ws;
			bit ng;
			r.idx = fi;
			if (fu || re) begin
				acc_sum = '0;
				wt_sum = '0;
				r.bim = 0;
				r.lag = 0;
				r.cl = fu ? blmr_pkg::CL_UNDEF : blmr_pkg::CL_ISOLATED;
				pending.push_back(r);
				return;
			end
			if (ni != fi && !nu && ni < MAX_OBS) begin
				p = longint'(w) * longint'(z2);
				acc = longint'(acc_sum) + p;
				ws = int'(wt_sum) + int'(w);
				if (acc > 64'sd36028797018963967) acc = 64'sd36028797018963967;
				if (acc < -64'sd36028797018963968) acc = -64'sd36028797018963968;
				if (ws > 24'hFFFFFF) ws = 24'hFFFFFF;
				acc_sum = acc[55:0];
				wt_sum = ws[23:0];
			end
			if (!last) return;
			lagv = 0;
			if (wt_sum != 0) begin
				acc = acc_sum;
				ng = acc < 0;
				um = ng ? longint'(-acc) : longint'(acc);
				um = um / longint'(wt_sum);
				if (um > 64'h80000000) um = 64'h80000000;
				lagv = ng ? -longint'(um) : longint'(um);
				if (lagv > 2147483647) lagv = 2147483647;
			end
			prod = longint'(z1) * lagv;
			ng = prod < 0;
			um = ng ? -prod : prod;
			um = um >> 24;
			if (um > 64'h80000000) um = 64'h80000000;
			mag = ng ? -longint'(um) : longint'(um);
			if (mag > 2147483647) mag = 2147483647;
			r.bim = mag[31:0];
			r.lag = lagv[31:0];
			if (z1 > 0 && lagv > 0) r.cl = blmr_pkg::CL_HH;
			else if (z1 < 0 && lagv < 0) r.cl = blmr_pkg::CL_LL;
			else if (z1 < 0 && lagv > 0) r.cl = blmr_pkg::CL_LH;
			else if (z1 > 0 && lagv < 0) r.cl = blmr_pkg::CL_HL;
			else r.cl = blmr_pkg::CL_NS;
			acc_sum = '0;
			wt_sum = '0;
			pending.push_back(r);
		endfunction

		function void check_row(logic [19:0] idx, logic signed [31:0] bim,
			logic signed [31:0] lag, logic [2:0] cl);
			row_result_t e;
			rows_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected word idx=%0d", idx);
				return;
			end
			e = pending.pop_front();
			if (idx !== e.idx || bim !== e.bim || lag !== e.lag || cl !== e.cl) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: exp idx=%0d bim=%0d lag=%0d cl=%0d, got %0d %0d %0d %0d",
						e.idx, e.bim, e.lag, e.cl, idx, bim, lag, cl);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [19:0] focal_index = '0;
	logic signed [31:0] focal_z1 = '0;
	logic focal_undefined = 1'b0;
	logic row_empty = 1'b0;
	logic [19:0] neighbor_index = '0;
	logic [16:0] neighbor_weight = '0;
	logic signed [31:0] neighbor_z2 = '0;
	logic neighbor_undefined = 1'b0;
	logic last_in_row = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [19:0] row_index;
	logic signed [31:0] bimoran;
	logic signed [31:0] spatial_lag;
	logic [2:0] cluster;

	int send_idle = 25;
	int recv_idle = 78;
	int hold_cycles = 0;
	moran_scoreboard sb;

	bivariate_local_moran_row i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.focal_index(focal_index), .focal_z1(focal_z1),
		.focal_undefined(focal_undefined), .row_empty(row_empty),
		.neighbor_index(neighbor_index), .neighbor_weight(neighbor_weight),
		.neighbor_z2(neighbor_z2), .neighbor_undefined(neighbor_undefined),
		.last_in_row(last_in_row), .empty(empty), .pop(pop),
		.row_index(row_index), .bimoran(bimoran), .spatial_lag(spatial_lag),
		.cluster(cluster)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check on the rising edge, choose pop at the falling edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_row(row_index, bimoran, spatial_lag, cluster);
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// push stays high after the word; the next call loads a new word or drops push, a drain drops it
	task automatic send_entry(logic [19:0] fi, logic signed [31:0] z1, logic fu,
		logic re, logic [19:0] ni, logic [16:0] w, logic signed [31:0] z2,
		logic nu, logic last);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		focal_index <= fi;
		focal_z1 <= z1;
		focal_undefined <= fu;
		row_empty <= re;
		neighbor_index <= ni;
		neighbor_weight <= w;
		neighbor_z2 <= z2;
		neighbor_undefined <= nu;
		last_in_row <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_entry(fi, z1, fu, re, ni, w, z2, nu, last);
		@(negedge clk);
	endtask

	// a well-formed row of the given length with random content, or extreme values when big is set
	task automatic send_row(int len, logic signed [31:0] z1, bit big);
		logic [19:0] fi;
		logic [19:0] ni;
		logic [16:0] w;
		logic signed [31:0] z2;
		int r;
		fi = 20'($urandom_range(20'hFFFFF));
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(9);
			ni = (r == 0) ? fi : 20'($urandom_range(20'hFFFFF));
			w = big ? 17'h10000 : ((r == 1) ? 17'h1FFFF : 17'($urandom_range(17'h1FFFF)));
			z2 = big ? ($urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000) : 32'($urandom);
			send_entry(fi, z1, 1'b0, 1'b0, ni, w, z2, (r == 2), k == len - 1);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n;
		logic signed [31:0] z1;
		sb = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: special rows and field extremes
		send_entry(20'hFFFFF, 32'sh7FFFFFFF, 1'b1, 1'b1, 20'd0, 17'd0, 32'sd0, 1'b0, 1'b0);
		send_entry(20'd0, 32'sh80000000, 1'b0, 1'b1, 20'd0, 17'd0, 32'sd0, 1'b0, 1'b0);
		send_entry(20'd5, 32'sh01000000, 1'b0, 1'b0, 20'd5, 17'h10000, 32'sh01000000,
			1'b0, 1'b1);
		send_entry(20'd5, 32'sh01000000, 1'b0, 1'b0, 20'd6, 17'h10000, 32'sh01000000,
			1'b1, 1'b1);
		send_entry(20'd7, -32'sh01000000, 1'b0, 1'b0, 20'd8, 17'h8000, 32'sh02000000,
			1'b0, 1'b0);
		send_entry(20'd7, -32'sh01000000, 1'b0, 1'b0, 20'd9, 17'h1FFFF, -32'sh3000000,
			1'b0, 1'b1);
		send_entry(20'd1, 32'sh7FFFFFFF, 1'b0, 1'b0, 20'hFFFFF, 17'd1, 32'sh7FFFFFFF,
			1'b0, 1'b1);
		send_entry(20'd1, 32'sh80000000, 1'b0, 1'b0, 20'd2, 17'd1, 32'sh80000000,
			1'b0, 1'b1);
		send_entry(20'd1, 32'sh7FFFFFFF, 1'b0, 1'b0, 20'd2, 17'h10000, 32'sh80000000,
			1'b0, 1'b1);
		send_entry(20'd3, 32'sh80000000, 1'b0, 1'b0, 20'd4, 17'h10000, 32'sh7FFFFFFF,
			1'b0, 1'b1);
		send_entry(20'd3, 32'sd0, 1'b0, 1'b0, 20'd4, 17'h10000, 32'sh7FFFFFFF, 1'b0, 1'b1);
		send_entry(20'd3, 32'sh00100000, 1'b0, 1'b0, 20'd4, 17'd0, 32'sh7FFFFFFF,
			1'b0, 1'b1);
		send_entry(20'd3, 32'sh00100000, 1'b0, 1'b0, 20'd4, 17'h10000, 32'sd0, 1'b0, 1'b1);
		send_row(20, 32'sh7FFFFFFF, 1'b1);
		wait_drained();

		// long receiver hold-off so the queue fills and stalls input
		hold_cycles = 600;
		for (int i = 0; i < 12; i++) send_entry(20'($urandom), 32'($urandom), 1'b0, 1'b0,
			20'($urandom), 17'($urandom), 32'($urandom), 1'b0, 1'b1);
		wait_drained();

		n = 0;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle = 78; recv_idle = 25; end
			if (ph == 2) begin send_idle = 0; recv_idle = 0; end
			while (n < (ph + 1) * N_RANDOM / 3) begin
				z1 = $urandom;
				case ($urandom_range(9))
					0: begin
						send_entry(20'($urandom), 32'($urandom), 1'($urandom), 1'($urandom),
							20'($urandom), 17'($urandom), 32'($urandom), 1'($urandom),
							1'($urandom));
						n++;
					end
					1: begin
						send_entry(20'($urandom), z1, 1'b0, 1'b1, 20'd0, 17'd0, 32'sd0,
							1'b0, 1'b0);
						n++;
					end
					default: begin
						int len;
						len = $urandom_range(1, 6);
						send_row(len, z1, 1'b0);
						n += len;
					end
				endcase
			end
			wait_drained();
		end

		$display("covered %0d finished rows over three idling phases and a full-queue stall",
			sb.rows_seen);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("mismatches: %0d", sb.errors);
			$display("simulation failed");
		end
		$finish;
	end
endmodule
